>>> rtl/core/tlcd_pkg.sv
// ============================================================================
// tlcd_pkg
// Shared types, character codes, status codes and command name tables for
// the text line command decoder.
// ============================================================================
package tlcd_pkg;

    // character codes
    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_STAR  = 8'h2A;
    localparam logic [7:0] CHR_SPACE = 8'h20;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NO_PREV = 3'd1;
    localparam logic [2:0] ST_BAD_SUM = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    // command codes
    localparam logic [2:0] CMD_STA      = 3'd0;
    localparam logic [2:0] CMD_SET      = 3'd1;
    localparam logic [2:0] CMD_GET      = 3'd2;
    localparam logic [2:0] CMD_SETTINGS = 3'd3;
    localparam logic [2:0] CMD_VERSION  = 3'd4;
    localparam logic [2:0] CMD_HELP     = 3'd5;

    // line terminator codes
    localparam logic [1:0] TERM_NONE = 2'd0;
    localparam logic [1:0] TERM_CR   = 2'd1;
    localparam logic [1:0] TERM_LF   = 2'd2;

    localparam int NUM_CMDS = 6;
    localparam logic [3:0] TOKEN_CAP = 4'd8;
    localparam logic [3:0] IDX_MAX   = 4'd15;

    // command names, one character per slot, zero padded
    localparam logic [7:0] CMD_CHARS [NUM_CMDS][8] = '{
        '{"s", "t", "a", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"g", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "e", "t", "t", "i", "n", "g", "s"},
        '{"v", "e", "r", "s", "i", "o", "n", 8'h00},
        '{"h", "e", "l", "p", 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] CMD_LENS [NUM_CMDS] = '{4'd3, 4'd3, 4'd3, 4'd8, 4'd7, 4'd4};

    // token tracker: count, in-token flag, first token index, name match mask
    typedef struct packed {
        logic [3:0] count;
        logic       in_tok;
        logic [3:0] idx;
        logic [5:0] mask;
    } trk_t;

    // stored decode for replay
    typedef struct packed {
        logic       valid;
        logic [2:0] status;
        logic [2:0] command;
        logic [3:0] count;
    } dec_t;

    // tracker control from the line logic
    typedef struct packed {
        logic       clear;
        logic       step;
        logic       star;
        logic [7:0] data;
    } trk_ctrl_t;

    localparam trk_t TRK_INIT = '{count: 4'd0, in_tok: 1'b0, idx: 4'd0, mask: 6'h3F};

    // hex digit value, msb flags a valid digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= "0" && c <= "9")
            r = {1'b1, c[3:0]};
        else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        return r;
    endfunction

    // advance the token tracker by one content byte
    function automatic trk_t trk_next(input trk_t t, input logic [7:0] b);
        trk_t r;
        logic go;
        r  = t;
        go = 1'b1;
        if (b == CHR_SPACE) begin
            r.in_tok = 1'b0;
            go = 1'b0;
        end else if (!t.in_tok) begin
            r.in_tok = 1'b1;
            if (t.count < TOKEN_CAP)
                r.count = 4'(t.count + 4'd1);
            else
                go = 1'b0;
        end
        if (go && r.count == 4'd1) begin
            for (int i = 0; i < NUM_CMDS; i++) begin
                if (t.idx >= CMD_LENS[i] || CMD_CHARS[i][t.idx[2:0]] != b)
                    r.mask[i] = 1'b0;
            end
            if (t.idx < IDX_MAX)
                r.idx = 4'(t.idx + 4'd1);
        end
        return r;
    endfunction

endpackage

>>> rtl/core/tlcd_in_if.sv
// ============================================================================
// tlcd_in_if
// Byte channel into the decoder: valid/ready handshake with one character.
// ============================================================================
interface tlcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

>>> rtl/core/tlcd_out_if.sv
// ============================================================================
// tlcd_out_if
// Decode result channel: valid/ready handshake with status, command, token
// count and replay flag.
// ============================================================================
interface tlcd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [2:0] command;
    logic [3:0] token_count;
    logic       replayed;

    modport source (output valid, output status, output command, output token_count,
                    output replayed, input ready);
    modport sink   (input valid, input status, input command, input token_count,
                    input replayed, output ready);
endinterface

>>> rtl/core/tlcd_tracker.sv
// ============================================================================
// tlcd_tracker
// Token tracker for the current line: counts space-delimited tokens and
// matches the first token against the command names, with a copy taken at
// each '*' so the body before the checksum can be decoded.
// ============================================================================
module tlcd_tracker
    import tlcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  trk_ctrl_t ctrl,
    output trk_t      cur,
    output trk_t      snap
);

    trk_t cur_reg, cur_next;
    trk_t snap_reg, snap_next;

    // next tracker state
    always_comb
    begin
        cur_next  = cur_reg;
        snap_next = snap_reg;
        if (ctrl.clear)
        begin
            cur_next  = TRK_INIT;
            snap_next = '0;
        end
        else if (ctrl.step)
        begin
            if (ctrl.star)
                snap_next = cur_reg;
            cur_next = trk_next(cur_reg, ctrl.data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg  <= TRK_INIT;
            snap_reg <= '0;
        end
        else
        begin
            cur_reg  <= cur_next;
            snap_reg <= snap_next;
        end
    end

    assign cur  = cur_reg;
    assign snap = snap_reg;

endmodule

>>> rtl/core/text_line_command_decoder.sv
// ============================================================================
// text_line_command_decoder
// Decodes a received character stream into one result per completed line:
// checksum suffix check, token count and command name match, with replay of
// the last stored decode on an empty line.
// ============================================================================
//
//  channel   dir   payload                                    transfer
//  chars     in    byte_in[7:0]                               valid & ready
//  decodes   out   status, command, token_count, replayed     valid & ready
//
//  one byte per cycle sustained while decodes are taken; a result is valid once
//  the terminator has passed the input register and then the decode has
//  landed in the result register
//  async active-low reset clears all line state and the stored decode
//  a result not taken holds the byte in the input register; chars stays ready
//  while the input register is empty or the result register can drain
//
module text_line_command_decoder
    import tlcd_pkg::*;
#(
    parameter int LINE_MAX = 64
)
(
    input logic        clk,
    input logic        rst_n,
    tlcd_in_if.sink    chars,
    tlcd_out_if.source decodes
);

    localparam int LEN_W = $clog2(LINE_MAX + 1);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_MAX);

    // input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;

    // line state
    logic [LEN_W-1:0] line_len_reg, line_len_next;
    logic [1:0]       pend_reg, pend_next;
    logic             ended_reg, ended_next;
    logic             content_nz_reg, content_nz_next;
    logic [7:0]       xor_reg, xor_next;
    logic             star_reg, star_next;
    logic             star_nz_reg, star_nz_next;
    logic [7:0]       xor_star_reg, xor_star_next;
    logic [15:0]      tail_reg, tail_next;
    logic [1:0]       tail_cnt_reg, tail_cnt_next;
    dec_t             last_reg, last_next;

    // result register
    logic       out_vld_reg;
    logic [2:0] out_status_reg;
    logic [2:0] out_command_reg;
    logic [3:0] out_count_reg;
    logic       out_replayed_reg;

    logic       advance;
    logic       emit;
    logic [2:0] res_status;
    logic [2:0] res_command;
    logic [3:0] res_count;
    logic       res_replayed;

    trk_ctrl_t  trk_ctrl;
    trk_t       trk_cur;
    trk_t       trk_snap;

    tlcd_tracker u_tracker (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (trk_ctrl),
        .cur   (trk_cur),
        .snap  (trk_snap)
    );

    // handshake
    assign advance     = in_vld_reg && (!out_vld_reg || decodes.ready);
    assign chars.ready = !in_vld_reg || !out_vld_reg || decodes.ready;

    // line processing and decode
    always_comb
    begin
        logic [7:0] b;
        logic       is_term;
        logic [1:0] t_code;
        logic [4:0] hi;
        logic [4:0] lo;
        logic       sum_ok;
        trk_t       t_sel;
        logic       body_nz;
        logic [2:0] m_status;
        logic [2:0] m_command;

        b       = in_byte_reg;
        is_term = (b == CHR_CR) || (b == CHR_LF);
        t_code  = (b == CHR_CR) ? TERM_CR : TERM_LF;

        // checksum suffix
        hi     = hex_val(tail_reg[15:8]);
        lo     = hex_val(tail_reg[7:0]);
        sum_ok = (tail_cnt_reg == 2'd2) && hi[4] && lo[4] &&
                 ({hi[3:0], lo[3:0]} == xor_star_reg);

        // command match on the body tokens
        t_sel   = star_reg ? trk_snap : trk_cur;
        body_nz = star_reg ? star_nz_reg : 1'b1;
        m_status  = ST_UNKNOWN;
        m_command = CMD_STA;
        if (t_sel.count == 4'd0)
            m_status = ST_EMPTY;
        else
        begin
            for (int i = NUM_CMDS - 1; i >= 0; i--)
            begin
                if (t_sel.mask[i] && t_sel.idx == CMD_LENS[i])
                begin
                    m_status  = ST_OK;
                    m_command = 3'(i);
                end
            end
        end

        line_len_next   = line_len_reg;
        pend_next       = pend_reg;
        ended_next      = ended_reg;
        content_nz_next = content_nz_reg;
        xor_next        = xor_reg;
        star_next       = star_reg;
        star_nz_next    = star_nz_reg;
        xor_star_next   = xor_star_reg;
        tail_next       = tail_reg;
        tail_cnt_next   = tail_cnt_reg;
        last_next       = last_reg;
        trk_ctrl        = '{clear: 1'b0, step: 1'b0, star: 1'b0, data: b};

        emit = 1'b0;
        // default result is a replay of the stored decode, or no-previous status when none is stored
        if (last_reg.valid)
        begin
            res_status   = last_reg.status;
            res_command  = last_reg.command;
            res_count    = last_reg.count;
            res_replayed = 1'b1;
        end
        else
        begin
            res_status   = ST_NO_PREV;
            res_command  = CMD_STA;
            res_count    = 4'd0;
            res_replayed = 1'b0;
        end

        if (advance)
        begin
            if (is_term)
            begin
                if (line_len_reg != '0)
                begin
                    // line closes: decode, then start a fresh line
                    emit      = 1'b1;
                    pend_next = t_code;
                    if (content_nz_reg && star_reg && !sum_ok)
                    begin
                        res_status   = ST_BAD_SUM;
                        res_command  = CMD_STA;
                        res_count    = 4'd0;
                        res_replayed = 1'b0;
                    end
                    else if (content_nz_reg)
                    begin
                        res_status   = m_status;
                        res_command  = m_command;
                        res_count    = t_sel.count;
                        res_replayed = 1'b0;
                        last_next    = '{valid: body_nz, status: m_status,
                                         command: m_command, count: t_sel.count};
                    end
                    line_len_next   = '0;
                    ended_next      = 1'b0;
                    content_nz_next = 1'b0;
                    xor_next        = 8'd0;
                    star_next       = 1'b0;
                    star_nz_next    = 1'b0;
                    xor_star_next   = 8'd0;
                    tail_next       = 16'd0;
                    tail_cnt_next   = 2'd0;
                    trk_ctrl.clear  = 1'b1;
                end
                else if (pend_reg != TERM_NONE && pend_reg != t_code)
                    // second half of a CR-LF or LF-CR pair
                    pend_next = TERM_NONE;
                else
                begin
                    // empty line replays
                    pend_next = TERM_NONE;
                    emit      = 1'b1;
                end
            end
            else
            begin
                pend_next = TERM_NONE;
                if (line_len_reg < LEN_LIMIT)
                begin
                    line_len_next = line_len_reg + 1'b1;
                    if (!ended_reg)
                    begin
                        if (b == CHR_NUL)
                            ended_next = 1'b1;
                        else
                        begin
                            if (b == CHR_STAR)
                            begin
                                star_next     = 1'b1;
                                star_nz_next  = content_nz_reg;
                                xor_star_next = xor_reg;
                                tail_next     = 16'd0;
                                tail_cnt_next = 2'd0;
                            end
                            else if (star_reg)
                            begin
                                tail_next = {tail_reg[7:0], b};
                                if (tail_cnt_reg != 2'd3)
                                    tail_cnt_next = tail_cnt_reg + 2'd1;
                            end
                            xor_next        = xor_reg ^ b;
                            content_nz_next = 1'b1;
                            trk_ctrl.step   = 1'b1;
                            trk_ctrl.star   = (b == CHR_STAR);
                        end
                    end
                end
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (chars.ready)
            in_vld_reg <= chars.valid;
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
            in_byte_reg <= chars.byte_in;
    end

    // line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len_reg   <= '0;
            pend_reg       <= TERM_NONE;
            ended_reg      <= 1'b0;
            content_nz_reg <= 1'b0;
            xor_reg        <= 8'd0;
            star_reg       <= 1'b0;
            star_nz_reg    <= 1'b0;
            xor_star_reg   <= 8'd0;
            tail_reg       <= 16'd0;
            tail_cnt_reg   <= 2'd0;
            last_reg       <= '0;
        end
        else
        begin
            line_len_reg   <= line_len_next;
            pend_reg       <= pend_next;
            ended_reg      <= ended_next;
            content_nz_reg <= content_nz_next;
            xor_reg        <= xor_next;
            star_reg       <= star_next;
            star_nz_reg    <= star_nz_next;
            xor_star_reg   <= xor_star_next;
            tail_reg       <= tail_next;
            tail_cnt_reg   <= tail_cnt_next;
            last_reg       <= last_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance && emit)
            out_vld_reg <= 1'b1;
        else if (decodes.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_status_reg   <= res_status;
            out_command_reg  <= res_command;
            out_count_reg    <= res_count;
            out_replayed_reg <= res_replayed;
        end
    end

    assign decodes.valid       = out_vld_reg;
    assign decodes.status      = out_status_reg;
    assign decodes.command     = out_command_reg;
    assign decodes.token_count = out_count_reg;
    assign decodes.replayed    = out_replayed_reg;

endmodule
